// ===== rtl/i64alu_pkg.sv =====
// Shared types, opcodes and helper functions for the 64-bit expression ALU.
package i64alu_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned KindWidth = 5;
    localparam int unsigned StatWidth = 2;
    localparam int unsigned DivBitsPerCell = 2;
    localparam int unsigned NumCells = DataWidth / DivBitsPerCell;

    typedef enum logic [KindWidth-1:0] {
        OP_PLUS = 5'd0, OP_NEG = 5'd1, OP_NOT = 5'd2, OP_INV = 5'd3,
        OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
        OP_EQ = 5'd8, OP_NE = 5'd9, OP_LT = 5'd10, OP_GT = 5'd11,
        OP_LE = 5'd12, OP_GE = 5'd13, OP_SHL = 5'd14, OP_SHR = 5'd15,
        OP_SWAP = 5'd16, OP_AND = 5'd17, OP_OR = 5'd18, OP_LAND = 5'd19,
        OP_LOR = 5'd20, OP_LXOR = 5'd21
    } kind_t;

    localparam logic [StatWidth-1:0] STAT_OK = 2'd0;
    localparam logic [StatWidth-1:0] STAT_DIV_ZERO = 2'd1;
    localparam logic [StatWidth-1:0] STAT_BAD_SWAP = 2'd2;

    // Swap selector decoded from the right operand.
    localparam logic [2:0] SWAP_NONE = 3'd0;
    localparam logic [2:0] SWAP_BIT = 3'd1;
    localparam logic [2:0] SWAP_PAIR = 3'd2;
    localparam logic [2:0] SWAP_NIBBLE = 3'd3;
    localparam logic [2:0] SWAP_BYTES16 = 3'd4;
    localparam logic [2:0] SWAP_BYTES32 = 3'd5;
    localparam logic [2:0] SWAP_BYTES64 = 3'd6;

    typedef struct packed {
        logic [KindWidth-1:0] kind;
        logic signed [DataWidth-1:0] left_value;
        logic signed [DataWidth-1:0] right_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] result_value;
        logic [StatWidth-1:0] status;
    } out_item_t;

    // State carried from cell to cell along the chain.
    typedef struct packed {
        logic valid;
        logic is_div;
        logic is_mul;
        logic neg_q;
        logic [DataWidth-1:0] rem;      // divide: partial remainder
        logic [DataWidth-1:0] quo;      // divide: dividend shifting into quotient
        logic [DataWidth-1:0] dsr;      // divide: divisor magnitude / mul: multiplier
        logic [DataWidth-1:0] acc;      // mul: product accumulator / other: result
        logic [DataWidth-1:0] mcand;    // mul: shifted multiplicand
        logic [StatWidth-1:0] status;
    } slot_t;

    function automatic logic [DataWidth-1:0] swap_fn(input logic [DataWidth-1:0] l,
                                                    input logic [2:0] sel);
        logic [DataWidth-1:0] v;
        v = '0;
        case (sel)
            SWAP_BIT:
                v = ((l >> 1) & 64'h5555555555555555)
                  | ((l << 1) & 64'haaaaaaaaaaaaaaaa);
            SWAP_PAIR:
                v = ((l >> 2) & 64'h3333333333333333)
                  | ((l << 2) & 64'hcccccccccccccccc);
            SWAP_NIBBLE:
                v = ((l >> 4) & 64'h0f0f0f0f0f0f0f0f)
                  | ((l << 4) & 64'hf0f0f0f0f0f0f0f0);
            SWAP_BYTES16: v = {48'd0, l[7:0], l[15:8]};
            SWAP_BYTES32: v = {32'd0, l[7:0], l[15:8], l[23:16], l[31:24]};
            SWAP_BYTES64: v = {l[7:0], l[15:8], l[23:16], l[31:24],
                               l[39:32], l[47:40], l[55:48], l[63:56]};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/i64alu_cell.sv =====
// One chain cell: a radix-4 divide step and a 4-bit multiply step, registered.
module i64alu_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  i64alu_pkg::slot_t  prev,
    output i64alu_pkg::slot_t  curr
);
    localparam int unsigned W = i64alu_pkg::DataWidth;
    localparam int unsigned MulBits = 4;

    i64alu_pkg::slot_t curr_reg, curr_next;
    logic [W-1:0] r_a, q_a, r_b, q_b;
    logic [W:0] t_a, t_b;
    logic [W-1:0] pp;

    always_comb
    begin
        curr_next = prev;
        // two restoring divide bits
        t_a = {prev.rem, prev.quo[W-1]} - {1'b0, prev.dsr};
        r_a = t_a[W] ? {prev.rem[W-2:0], prev.quo[W-1]} : t_a[W-1:0];
        q_a = {prev.quo[W-2:0], ~t_a[W]};
        t_b = {r_a, q_a[W-1]} - {1'b0, prev.dsr};
        r_b = t_b[W] ? {r_a[W-2:0], q_a[W-1]} : t_b[W-1:0];
        q_b = {q_a[W-2:0], ~t_b[W]};
        // four multiply bits
        pp = ({W{prev.dsr[0]}} & prev.mcand)
           + ({W{prev.dsr[1]}} & (prev.mcand << 1))
           + ({W{prev.dsr[2]}} & (prev.mcand << 2))
           + ({W{prev.dsr[3]}} & (prev.mcand << 3));
        if (prev.is_div)
        begin
            curr_next.rem = r_b;
            curr_next.quo = q_b;
        end
        if (prev.is_mul)
        begin
            curr_next.acc = prev.acc + pp;
            curr_next.mcand = prev.mcand << MulBits;
            curr_next.dsr = prev.dsr >> MulBits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            curr_reg <= '0;
        else if (advance)
            curr_reg <= curr_next;
    end

    assign curr = curr_reg;
endmodule

// ===== rtl/int64_expression_alu.sv =====
// Top level of the 64-bit expression ALU: decode, cell chain and output stage.
//
// One item enters per cycle, back to back, unless the input is stalled.
// Each item passes 34 register stages: one decode stage, a chain of 32
// identical cells, and one finishing stage that holds the result item.
// Every operation runs down the same chain so items stay in order; divide
// is the figure that sets the length, each cell retiring two quotient bits
// (64 bits / 2 = 32 cells), while multiply retires four multiplier bits per
// cell in the first 16 cells. The chain advances whenever the finishing
// register is empty or is being taken; while a finished item waits on a
// stall, every stage holds and the input is stalled. Divide by zero gives
// 0 with status 1, an unsupported swap width 0 with status 2.
module int64_expression_alu (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  i64alu_pkg::in_item_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output i64alu_pkg::out_item_t  out_data
);
    localparam int unsigned W = i64alu_pkg::DataWidth;
    localparam int unsigned NumCells = i64alu_pkg::NumCells;

    logic advance;
    i64alu_pkg::slot_t head_reg, head_next;
    i64alu_pkg::slot_t chain [NumCells+1];
    i64alu_pkg::out_item_t out_reg, out_next;
    logic out_valid_reg;

    logic [W-1:0] l, r, ma, mb;
    logic [5:0] sh;
    logic lt, gt, lnz, rnz;
    logic [2:0] swap_sel;

    // Advance the whole pipe when the output slot frees up.
    assign advance = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // Decode: finish every operation but divide and multiply, seed divide and multiply.
    always_comb
    begin
        l = in_data.left_value;
        r = in_data.right_value;
        sh = r[5:0];
        lt = $signed(l) < $signed(r);
        gt = $signed(r) < $signed(l);
        lnz = |l;
        rnz = |r;
        ma = l[W-1] ? (~l + 1'b1) : l;
        mb = r[W-1] ? (~r + 1'b1) : r;
        case (r)
            64'd1:  swap_sel = i64alu_pkg::SWAP_BIT;
            64'd2:  swap_sel = i64alu_pkg::SWAP_PAIR;
            64'd4:  swap_sel = i64alu_pkg::SWAP_NIBBLE;
            64'd16: swap_sel = i64alu_pkg::SWAP_BYTES16;
            64'd32: swap_sel = i64alu_pkg::SWAP_BYTES32;
            64'd64: swap_sel = i64alu_pkg::SWAP_BYTES64;
            default: swap_sel = i64alu_pkg::SWAP_NONE;
        endcase
        head_next = '0;
        head_next.valid = in_valid;
        head_next.status = i64alu_pkg::STAT_OK;
        case (in_data.kind)
            i64alu_pkg::OP_PLUS: head_next.acc = l;
            i64alu_pkg::OP_NEG:  head_next.acc = ~l + 1'b1;
            i64alu_pkg::OP_NOT:  head_next.acc = {63'd0, !lnz};
            i64alu_pkg::OP_INV:  head_next.acc = ~l;
            i64alu_pkg::OP_ADD:  head_next.acc = l + r;
            i64alu_pkg::OP_SUB:  head_next.acc = l - r;
            i64alu_pkg::OP_MUL:
            begin
                head_next.is_mul = 1'b1;
                head_next.mcand = l;
                head_next.dsr = r;
            end
            i64alu_pkg::OP_DIV:
            begin
                if (!rnz)
                    head_next.status = i64alu_pkg::STAT_DIV_ZERO;
                else
                begin
                    head_next.is_div = 1'b1;
                    head_next.quo = ma;
                    head_next.dsr = mb;
                    head_next.neg_q = l[W-1] ^ r[W-1];
                end
            end
            i64alu_pkg::OP_EQ:   head_next.acc = {63'd0, l == r};
            i64alu_pkg::OP_NE:   head_next.acc = {63'd0, l != r};
            i64alu_pkg::OP_LT:   head_next.acc = {63'd0, lt};
            i64alu_pkg::OP_GT:   head_next.acc = {63'd0, gt};
            i64alu_pkg::OP_LE:   head_next.acc = {63'd0, !gt};
            i64alu_pkg::OP_GE:   head_next.acc = {63'd0, !lt};
            i64alu_pkg::OP_SHL:  head_next.acc = l << sh;
            i64alu_pkg::OP_SHR:  head_next.acc = $unsigned($signed(l) >>> sh);
            i64alu_pkg::OP_SWAP:
            begin
                head_next.acc = i64alu_pkg::swap_fn(l, swap_sel);
                if (swap_sel == i64alu_pkg::SWAP_NONE)
                    head_next.status = i64alu_pkg::STAT_BAD_SWAP;
            end
            i64alu_pkg::OP_AND:  head_next.acc = l & r;
            i64alu_pkg::OP_OR:   head_next.acc = l | r;
            i64alu_pkg::OP_LAND: head_next.acc = {63'd0, lnz && rnz};
            i64alu_pkg::OP_LOR:  head_next.acc = {63'd0, lnz || rnz};
            i64alu_pkg::OP_LXOR: head_next.acc = {63'd0, lnz != rnz};
            default:             head_next.acc = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_reg <= '0;
        else if (advance)
            head_reg <= head_next;
    end

    assign chain[0] = head_reg;

    for (genvar g = 0; g < NumCells; g++)
    begin : g_cell
        i64alu_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .prev    (chain[g]),
            .curr    (chain[g+1])
        );
    end

    // Finish: sign-correct the quotient, pick the result.
    always_comb
    begin
        out_next.status = chain[NumCells].status;
        if (chain[NumCells].is_div)
            out_next.result_value = chain[NumCells].neg_q
                ? (~chain[NumCells].quo + 1'b1) : chain[NumCells].quo;
        else
            out_next.result_value = chain[NumCells].acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[NumCells].valid;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // Nothing enters while the held result is stalled.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output stalled");
    // Held result stays put while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
    // Status is never an undefined code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= i64alu_pkg::STAT_BAD_SWAP))
        else $error("bad status code");
    // Divide by zero always reports zero.
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == i64alu_pkg::STAT_DIV_ZERO)
            |-> (out_data.result_value == '0))
        else $error("divide by zero with nonzero result");
endmodule
